// ===== src/rgbf_pkg.sv =====
package rgbf_pkg;

  localparam int DUTY_BITS = 12;
  localparam int PEAK_BITS = 12;
  localparam int STEP_BITS = 8;
  localparam int SPEED_BITS = 8;
  localparam int ELAPSED_BITS = 9;
  localparam int COLOR_BITS = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 12;
  // signed width that holds a level or the peak plus or minus one step
  localparam int FADE_BITS = ((DUTY_BITS > PEAK_BITS) ? DUTY_BITS : PEAK_BITS) + 2;

  localparam logic [DUTY_BITS-1:0] FULL_SCALE = '1;

  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_COLOR = 3'd1;
  localparam logic [2:0] ACT_MODE  = 3'd2;
  localparam logic [2:0] ACT_POWER = 3'd3;
  localparam logic [2:0] ACT_SPEED = 3'd4;

  localparam logic [1:0] MODE_STATIC  = 2'd0;
  localparam logic [1:0] MODE_RAINBOW = 2'd1;
  localparam logic [1:0] MODE_STROBE  = 2'd2;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] REG_PEAK = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_STEP = 2'd1;

  localparam logic [PEAK_BITS-1:0] PEAK_RST = 12'd4095;
  localparam logic [STEP_BITS-1:0] STEP_RST = 8'd5;
  localparam logic [SPEED_BITS-1:0] SPEED_RST = 8'd100;
  localparam logic [ELAPSED_BITS-1:0] ELAPSED_CAP = 9'd256;

  typedef logic [2:0][DUTY_BITS-1:0] lvl_vec_t;

  typedef struct packed {
    logic [2:0]            action;
    logic [COLOR_BITS-1:0] red;
    logic [COLOR_BITS-1:0] green;
    logic [COLOR_BITS-1:0] blue;
    logic [1:0]            mode_value;
    logic                  power_value;
    logic [SPEED_BITS-1:0] speed_value;
  } in_item_t;

  typedef struct packed {
    logic [DUTY_BITS-1:0] red_duty;
    logic [DUTY_BITS-1:0] green_duty;
    logic [DUTY_BITS-1:0] blue_duty;
    logic                 lamp_on;
    logic [1:0]           active_mode;
  } out_item_t;

  typedef struct packed {
    lvl_vec_t   lvl;
    logic [1:0] rise;
    logic [1:0] fall;
  } fade_res_t;

endpackage

// ===== src/rgbf_fade.sv =====
module rgbf_fade
  import rgbf_pkg::*;
(
  input  lvl_vec_t              lvl,
  input  logic [1:0]            rise,
  input  logic [1:0]            fall,
  input  logic [PEAK_BITS-1:0]  peak,
  input  logic [STEP_BITS-1:0]  step,
  output fade_res_t             res
);

  localparam logic signed [FADE_BITS-1:0] FULL_T =
    $signed({{(FADE_BITS-DUTY_BITS){1'b0}}, FULL_SCALE});

  function automatic logic [1:0] next_ch(input logic [1:0] ch);
    return (ch == CH_BLUE) ? CH_RED : ch + 2'd1;
  endfunction

  logic signed [FADE_BITS-1:0] t [3];
  logic signed [FADE_BITS-1:0] pk;
  logic signed [FADE_BITS-1:0] stp;
  logic [1:0] up;
  logic [1:0] dn;

  always_comb begin
    pk  = $signed({{(FADE_BITS-PEAK_BITS){1'b0}}, peak});
    stp = $signed({{(FADE_BITS-STEP_BITS){1'b0}}, step});
    up  = (rise == 2'd3) ? CH_RED : rise;
    dn  = (fall == 2'd3) ? CH_RED : fall;
    res.rise = rise;
    res.fall = fall;
    for (int i = 0; i < 3; i++) begin
      t[i] = $signed({{(FADE_BITS-DUTY_BITS){1'b0}}, lvl[i]});
    end
    t[up] = t[up] + stp;
    t[dn] = t[dn] - stp;
    // rising check first, falling check sees its result when both match
    if (t[up] >= pk) begin
      t[up] = pk;
      res.rise = next_ch(up);
    end
    if (t[dn] < 0 || t[dn] >= pk) begin
      t[dn] = '0;
      res.fall = next_ch(dn);
    end
    for (int i = 0; i < 3; i++) begin
      if (t[i] < 0) begin
        res.lvl[i] = '0;
      end else if (t[i] > FULL_T) begin
        res.lvl[i] = FULL_SCALE;
      end else begin
        res.lvl[i] = t[i][DUTY_BITS-1:0];
      end
    end
  end

endmodule

// ===== src/rgb_led_rainbow_fader.sv =====
// Rainbow crossfader for three PWM duty levels. Each input item is one event
// (a 1 ms tick or a write of color, mode, power or speed); each item gives
// exactly one result item with the duty levels after that event, zero while
// the lamp is off. One item is taken every clock cycle and its result appears
// in the cycle after acceptance: the whole state update, including a fade step,
// is a single combinational pass into the state and result registers. The
// result register is refilled while it is being taken, so a stall comes only
// from out_ready. Configuration (0 peak, 1 fade step) is written through the
// cfg port, which is always ready, and should be written while the block idles.
module rgb_led_rainbow_fader
  import rgbf_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  function automatic logic [DUTY_BITS-1:0] sat_color(input logic [COLOR_BITS-1:0] v);
    if (v > COLOR_BITS'(FULL_SCALE)) begin
      return FULL_SCALE;
    end
    return v[DUTY_BITS-1:0];
  endfunction

  localparam lvl_vec_t LVL_RST = {{DUTY_BITS{1'b0}}, {DUTY_BITS{1'b0}}, FULL_SCALE};

  logic [PEAK_BITS-1:0]    peak_r;
  logic [STEP_BITS-1:0]    step_r;
  lvl_vec_t                lvl_r, lvl_nxt;
  logic [1:0]              mode_r, mode_nxt;
  logic                    pwr_r, pwr_nxt;
  logic [SPEED_BITS-1:0]   speed_r, speed_nxt;
  logic [1:0]              rise_r, rise_nxt;
  logic [1:0]              fall_r, fall_nxt;
  logic [ELAPSED_BITS-1:0] elapsed_r, elapsed_nxt;
  logic                    out_valid_r;
  out_item_t               out_data_r, out_data_nxt;

  logic [ELAPSED_BITS-1:0] elapsed_inc;
  logic                    fire;
  logic                    in_acc;
  fade_res_t               fade;

  rgbf_fade u_fade (
    .lvl  (lvl_r),
    .rise (rise_r),
    .fall (fall_r),
    .peak (peak_r),
    .step (step_r),
    .res  (fade)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    elapsed_inc = (elapsed_r < ELAPSED_CAP) ? elapsed_r + 1'b1 : elapsed_r;
    fire = (mode_r == MODE_RAINBOW) && pwr_r &&
           (({1'b0, elapsed_inc} + {2'b0, speed_r}) > 10'd255);
    lvl_nxt     = lvl_r;
    mode_nxt    = mode_r;
    pwr_nxt     = pwr_r;
    speed_nxt   = speed_r;
    rise_nxt    = rise_r;
    fall_nxt    = fall_r;
    elapsed_nxt = elapsed_r;
    case (in_data.action)
      ACT_TICK: begin
        elapsed_nxt = elapsed_inc;
        if (fire) begin
          elapsed_nxt = '0;
          lvl_nxt     = fade.lvl;
          rise_nxt    = fade.rise;
          fall_nxt    = fade.fall;
        end
      end
      ACT_COLOR: begin
        lvl_nxt[0] = sat_color(in_data.red);
        lvl_nxt[1] = sat_color(in_data.green);
        lvl_nxt[2] = sat_color(in_data.blue);
        pwr_nxt    = 1'b1;
      end
      ACT_MODE: begin
        mode_nxt = (in_data.mode_value > MODE_STROBE) ? MODE_STROBE : in_data.mode_value;
        pwr_nxt  = 1'b1;
        if (in_data.mode_value == MODE_RAINBOW) begin
          lvl_nxt = LVL_RST;
        end
      end
      ACT_POWER: begin
        pwr_nxt = in_data.power_value;
      end
      ACT_SPEED: begin
        speed_nxt = in_data.speed_value;
        pwr_nxt   = 1'b1;
      end
      default: begin
      end
    endcase
    out_data_nxt.red_duty    = pwr_nxt ? lvl_nxt[0] : '0;
    out_data_nxt.green_duty  = pwr_nxt ? lvl_nxt[1] : '0;
    out_data_nxt.blue_duty   = pwr_nxt ? lvl_nxt[2] : '0;
    out_data_nxt.lamp_on     = pwr_nxt;
    out_data_nxt.active_mode = mode_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r      <= PEAK_RST;
      step_r      <= STEP_RST;
      lvl_r       <= LVL_RST;
      mode_r      <= MODE_STATIC;
      pwr_r       <= 1'b1;
      speed_r     <= SPEED_RST;
      rise_r      <= CH_GREEN;
      fall_r      <= CH_RED;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PEAK: peak_r <= cfg_data[PEAK_BITS-1:0];
          REG_STEP: step_r <= cfg_data[STEP_BITS-1:0];
          default: begin
          end
        endcase
      end
      if (in_acc) begin
        lvl_r       <= lvl_nxt;
        mode_r      <= mode_nxt;
        pwr_r       <= pwr_nxt;
        speed_r     <= speed_nxt;
        rise_r      <= rise_nxt;
        fall_r      <= fall_nxt;
        elapsed_r   <= elapsed_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= out_data_nxt;
    end
  end

  // power off write shows up as a dark lamp in the next result
  a_power_off: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.action == ACT_POWER && !in_data.power_value |=>
      out_valid && !out_data.lamp_on && out_data.red_duty == '0 &&
      out_data.green_duty == '0 && out_data.blue_duty == '0)
    else $error("power off item did not darken the outputs");

  // color write switches the lamp on
  a_color_on: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.action == ACT_COLOR |=> out_valid && out_data.lamp_on)
    else $error("color item did not switch the lamp on");

  // input stalls only behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a pending result");

  // channel pointers stay within the three channels
  a_ch_range: assert property (@(posedge clk) disable iff (!rst_n)
    rise_r != 2'd3 && fall_r != 2'd3)
    else $error("fade channel pointer out of range");

endmodule
